@@ rtl/core/gprb_pkg.sv @@
// ---------------------------------------------------------------------------
// Gamepad report builder package
// Shared types and constants for the report builder core.
// ---------------------------------------------------------------------------
package gprb_pkg;

	localparam int FINGER_SLOTS = 2;
	localparam int FINGER_COUNT = 2;
	localparam int COORD_W      = 12;

	localparam logic       CFG_PAD_MAX_X = 1'b0;
	localparam logic       CFG_PAD_MAX_Y = 1'b1;

	localparam logic [11:0] PAD_MAX_X_RST = 12'd1919;
	localparam logic [11:0] PAD_MAX_Y_RST = 12'd942;
	localparam logic [5:0]  FRAME_RST     = 6'h3F;
	localparam logic [7:0]  TOUCH_STEP    = 8'd4;
	localparam logic [7:0]  ID_ABSENT     = 8'h80;
	localparam logic [31:0] WORD_DISABLED = 32'h0000_0080;

	// hat codes carried in the low nibble of hat_and_face
	localparam logic [3:0] HAT_UP         = 4'd0;
	localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
	localparam logic [3:0] HAT_RIGHT      = 4'd2;
	localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
	localparam logic [3:0] HAT_DOWN       = 4'd4;
	localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
	localparam logic [3:0] HAT_LEFT       = 4'd6;
	localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
	localparam logic [3:0] HAT_NEUTRAL    = 4'd8;

	typedef struct packed {
		logic signed [10:0] left_stick_x;
		logic signed [10:0] left_stick_y;
		logic signed [10:0] right_stick_x;
		logic signed [10:0] right_stick_y;
		logic [15:0]        digital_buttons;
		logic [9:0]         left_trigger;
		logic [9:0]         right_trigger;
		logic [1:0]         finger_present;
		logic signed [12:0] finger1_dx;
		logic signed [12:0] finger1_dy;
		logic signed [12:0] finger2_dx;
		logic signed [12:0] finger2_dy;
	} sample_t;

	typedef struct packed {
		logic [7:0] left_x_byte;
		logic [7:0] left_y_byte;
		logic [7:0] right_x_byte;
		logic [7:0] right_y_byte;
		logic [7:0] hat_and_face;
		logic [9:0] buttons;
		logic [7:0] left_trigger_byte;
		logic [7:0] right_trigger_byte;
	} pack_t;

	typedef struct packed {
		logic [11:0] pad_max_x;
		logic [11:0] pad_max_y;
	} pad_cfg_t;

endpackage

@@ rtl/core/gprb_if.sv @@
// ---------------------------------------------------------------------------
// Gamepad report builder channels
// Sample, report and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface gprb_sample_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] left_stick_x;
	logic signed [10:0] left_stick_y;
	logic signed [10:0] right_stick_x;
	logic signed [10:0] right_stick_y;
	logic [15:0]        digital_buttons;
	logic [9:0]         left_trigger;
	logic [9:0]         right_trigger;
	logic [1:0]         finger_present;
	logic signed [12:0] finger1_dx;
	logic signed [12:0] finger1_dy;
	logic signed [12:0] finger2_dx;
	logic signed [12:0] finger2_dy;

	modport source (
		output valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
		       digital_buttons, left_trigger, right_trigger, finger_present,
		       finger1_dx, finger1_dy, finger2_dx, finger2_dy,
		input  ready
	);
	modport sink (
		input  valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
		       digital_buttons, left_trigger, right_trigger, finger_present,
		       finger1_dx, finger1_dy, finger2_dx, finger2_dy,
		output ready
	);
endinterface

interface gprb_report_if;
	logic        valid;
	logic        ready;
	logic [7:0]  left_x_byte;
	logic [7:0]  left_y_byte;
	logic [7:0]  right_x_byte;
	logic [7:0]  right_y_byte;
	logic [7:0]  hat_and_face;
	logic [15:0] buttons_and_frame;
	logic [7:0]  left_trigger_byte;
	logic [7:0]  right_trigger_byte;
	logic [7:0]  touch_packet_count;
	logic [31:0] finger1_word;
	logic [31:0] finger2_word;
	logic        report_valid;

	modport source (
		output valid, left_x_byte, left_y_byte, right_x_byte, right_y_byte,
		       hat_and_face, buttons_and_frame, left_trigger_byte,
		       right_trigger_byte, touch_packet_count, finger1_word,
		       finger2_word, report_valid,
		input  ready
	);
	modport sink (
		input  valid, left_x_byte, left_y_byte, right_x_byte, right_y_byte,
		       hat_and_face, buttons_and_frame, left_trigger_byte,
		       right_trigger_byte, touch_packet_count, finger1_word,
		       finger2_word, report_valid,
		output ready
	);
endinterface

interface gprb_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/gamepad_report_builder_unit.sv @@
// ---------------------------------------------------------------------------
// Gamepad report builder
// Turns one controller sample into one packed input report.
// ---------------------------------------------------------------------------
// Usage:
//   sample  - controller samples in, one transfer per report.
//   report  - packed report fields out, one transfer per accepted sample.
//   cfg     - pad size registers (index 0 pad_max_x, index 1 pad_max_y);
//             always ready, write only while no report is in flight.
// Pipeline: input register, then result register. Throughput: one sample per
// cycle while reports are taken; the two-stage pipeline with an output
// register keeps the sample side open while a finished report waits for the
// receiver, until the input register fills.
// Frame counter, touch counter and finger state step as an item moves from
// the input register into the result register, so the state registers are
// the report's own fields and hold with it.
// Reset: frame counter 63 (first report carries 0), touch counter 0, both
// fingers absent, pad size 1919 x 942, both stages empty.
// Stall: a stalled report holds; the input register fills, then sample ready
// drops until the report transfers.
// ---------------------------------------------------------------------------
module gamepad_report_builder_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	gprb_sample_if.sink          sample,
	gprb_report_if.source        report,
	gprb_cfg_if.sink             cfg
);

	gprb_pkg::sample_t  sample_in;
	gprb_pkg::sample_t  sample_s1;
	logic               valid_s1;
	gprb_pkg::pack_t    fields;
	gprb_pkg::pack_t    fields_s2;
	logic               valid_s2;
	gprb_pkg::pad_cfg_t pad_q;
	logic [5:0]         frame_q;
	logic [7:0]         touch_count;
	logic [31:0]        finger_word [gprb_pkg::FINGER_SLOTS];
	logic               s2_free;
	logic               advance;

	// gather the channel into one word for the input register
	always_comb begin
		sample_in.left_stick_x    = sample.left_stick_x;
		sample_in.left_stick_y    = sample.left_stick_y;
		sample_in.right_stick_x   = sample.right_stick_x;
		sample_in.right_stick_y   = sample.right_stick_y;
		sample_in.digital_buttons = sample.digital_buttons;
		sample_in.left_trigger    = sample.left_trigger;
		sample_in.right_trigger   = sample.right_trigger;
		sample_in.finger_present  = sample.finger_present;
		sample_in.finger1_dx      = sample.finger1_dx;
		sample_in.finger1_dy      = sample.finger1_dy;
		sample_in.finger2_dx      = sample.finger2_dx;
		sample_in.finger2_dy      = sample.finger2_dy;
	end

	// result register can take a new report when empty or draining
	assign s2_free      = !valid_s2 || report.ready;
	assign advance      = valid_s1 && s2_free;
	assign sample.ready = !valid_s1 || s2_free;
	assign cfg.ready    = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample_in;
		end
	end

	// pad size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q.pad_max_x <= gprb_pkg::PAD_MAX_X_RST;
			pad_q.pad_max_y <= gprb_pkg::PAD_MAX_Y_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				gprb_pkg::CFG_PAD_MAX_X: pad_q.pad_max_x <= cfg.data;
				gprb_pkg::CFG_PAD_MAX_Y: pad_q.pad_max_y <= cfg.data;
				default: ;
			endcase
		end
	end

	gprb_pack u_pack (
		.sample (sample_s1),
		.fields (fields)
	);

	gprb_touch u_touch (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.sample      (sample_s1),
		.pad         (pad_q),
		.touch_count (touch_count),
		.finger_word (finger_word)
	);

	// frame counter steps with each report and wraps at 64
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= gprb_pkg::FRAME_RST;
		end else if (advance) begin
			frame_q <= frame_q + 6'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fields_s2 <= fields;
		end
	end

	assign report.valid              = valid_s2;
	assign report.left_x_byte        = fields_s2.left_x_byte;
	assign report.left_y_byte        = fields_s2.left_y_byte;
	assign report.right_x_byte       = fields_s2.right_x_byte;
	assign report.right_y_byte       = fields_s2.right_y_byte;
	assign report.hat_and_face       = fields_s2.hat_and_face;
	assign report.buttons_and_frame  = {frame_q, fields_s2.buttons};
	assign report.left_trigger_byte  = fields_s2.left_trigger_byte;
	assign report.right_trigger_byte = fields_s2.right_trigger_byte;
	assign report.touch_packet_count = touch_count;
	assign report.finger1_word       = finger_word[0];
	assign report.finger2_word       = finger_word[1];
	assign report.report_valid       = 1'b1;

endmodule

@@ rtl/core/gprb_pack.sv @@
// ---------------------------------------------------------------------------
// Gamepad report field packer
// Stick and trigger saturation, hat encoding and button packing.
// ---------------------------------------------------------------------------
module gprb_pack (
	input  gprb_pkg::sample_t sample,
	output gprb_pkg::pack_t   fields
);

	// offset by 128, clamp to a byte
	function automatic logic [7:0] stick_byte(input logic signed [10:0] pos);
		logic signed [11:0] sum;
		sum = {pos[10], pos} + 12'sd128;
		if (sum[11])
			stick_byte = 8'h00;
		else if (sum[10:8] != 3'b000)
			stick_byte = 8'hFF;
		else
			stick_byte = sum[7:0];
	endfunction

	function automatic logic [7:0] trigger_byte(input logic [9:0] t);
		trigger_byte = (t[9:8] != 2'b00) ? 8'hFF : t[7:0];
	endfunction

	logic       up, right, down, left;
	logic [3:0] hat;

	assign up    = sample.digital_buttons[0];
	assign right = sample.digital_buttons[1];
	assign down  = sample.digital_buttons[2];
	assign left  = sample.digital_buttons[3];

	// right beats left, down beats up
	always_comb begin
		if (right)
			hat = down ? gprb_pkg::HAT_DOWN_RIGHT
			           : (up ? gprb_pkg::HAT_UP_RIGHT : gprb_pkg::HAT_RIGHT);
		else if (left)
			hat = down ? gprb_pkg::HAT_DOWN_LEFT
			           : (up ? gprb_pkg::HAT_UP_LEFT : gprb_pkg::HAT_LEFT);
		else if (down)
			hat = gprb_pkg::HAT_DOWN;
		else if (up)
			hat = gprb_pkg::HAT_UP;
		else
			hat = gprb_pkg::HAT_NEUTRAL;
	end

	always_comb begin
		fields.left_x_byte        = stick_byte(sample.left_stick_x);
		fields.left_y_byte        = stick_byte(sample.left_stick_y);
		fields.right_x_byte       = stick_byte(sample.right_stick_x);
		fields.right_y_byte       = stick_byte(sample.right_stick_y);
		fields.hat_and_face       = {sample.digital_buttons[7:4], hat};
		fields.buttons            = {sample.digital_buttons[15:10],
		                             (sample.right_trigger != 10'd0),
		                             (sample.left_trigger != 10'd0),
		                             sample.digital_buttons[9:8]};
		fields.left_trigger_byte  = trigger_byte(sample.left_trigger);
		fields.right_trigger_byte = trigger_byte(sample.right_trigger);
	end

endmodule

@@ rtl/core/gprb_touch.sv @@
// ---------------------------------------------------------------------------
// Gamepad touch tracker
// Finger position, id and touch packet state, stepped once per report.
// ---------------------------------------------------------------------------
module gprb_touch (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  gprb_pkg::sample_t sample,
	input  gprb_pkg::pad_cfg_t pad,
	output logic [7:0]        touch_count,
	output logic [31:0]       finger_word [gprb_pkg::FINGER_SLOTS]
);

	logic [7:0]                      id_q [gprb_pkg::FINGER_SLOTS];
	logic [gprb_pkg::COORD_W-1:0]    x_q  [gprb_pkg::FINGER_SLOTS];
	logic [gprb_pkg::COORD_W-1:0]    y_q  [gprb_pkg::FINGER_SLOTS];
	logic [7:0]                      touch_q;
	logic signed [12:0]              dx [gprb_pkg::FINGER_SLOTS];
	logic signed [12:0]              dy [gprb_pkg::FINGER_SLOTS];
	logic [gprb_pkg::FINGER_SLOTS-1:0] present;

	assign dx[0] = sample.finger1_dx;
	assign dy[0] = sample.finger1_dy;
	assign dx[1] = sample.finger2_dx;
	assign dy[1] = sample.finger2_dy;

	// clamp start + delta into 0..limit
	function automatic logic [11:0] move_clamp(input logic [11:0] start,
	                                           input logic signed [12:0] delta,
	                                           input logic [11:0] limit);
		logic signed [14:0] sum;
		sum = $signed({3'b000, start}) + $signed({{2{delta[12]}}, delta});
		if (sum[14])
			move_clamp = 12'd0;
		else if (sum[13:0] > {2'b00, limit})
			move_clamp = limit;
		else
			move_clamp = sum[11:0];
	endfunction

	for (genvar k = 0; k < gprb_pkg::FINGER_SLOTS; k++) begin : g_finger
		logic        new_touch;
		logic [7:0]  id_inc;
		logic [11:0] start_x, start_y;

		// slots beyond the enabled count never touch
		assign present[k] = sample.finger_present[k] && (k < gprb_pkg::FINGER_COUNT);
		assign new_touch  = id_q[k][7];
		assign id_inc     = id_q[k] + 8'd1;
		assign start_x    = new_touch ? (pad.pad_max_x >> 1) : x_q[k];
		assign start_y    = new_touch ? (pad.pad_max_y >> 1) : y_q[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				id_q[k] <= gprb_pkg::ID_ABSENT;
				x_q[k]  <= '0;
				y_q[k]  <= '0;
			end else if (advance) begin
				if (present[k]) begin
					id_q[k] <= {1'b0, new_touch ? id_inc[6:0] : id_q[k][6:0]};
					x_q[k]  <= move_clamp(start_x, dx[k], pad.pad_max_x);
					y_q[k]  <= move_clamp(start_y, dy[k], pad.pad_max_y);
				end else begin
					id_q[k][7] <= 1'b1;
				end
			end
		end

		assign finger_word[k] = (k < gprb_pkg::FINGER_COUNT)
			? {y_q[k][11:4], y_q[k][3:0], x_q[k][11:8], x_q[k][7:0], id_q[k]}
			: gprb_pkg::WORD_DISABLED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_q <= '0;
		end else if (advance && (present != '0)) begin
			touch_q <= touch_q + gprb_pkg::TOUCH_STEP;
		end
	end

	assign touch_count = touch_q;

endmodule
